>>> hdl/r16id_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r16id_pkg
// Mnemonic and operand-format codes and the word decode function for the
// 16-bit instruction decoder.
// ----------------------------------------------------------------------------
package r16id_pkg;

	localparam int MnemW = 7;
	localparam int FmtW  = 6;

	typedef logic [MnemW-1:0] mnem_t;
	typedef logic [FmtW-1:0]  fmt_t;

	typedef struct packed {
		mnem_t mnem;
		fmt_t  fmt;
	} dec_t;

	// mnemonic codes
	localparam mnem_t M_ADD    = 7'd0;
	localparam mnem_t M_ADDC   = 7'd1;
	localparam mnem_t M_ADDV   = 7'd2;
	localparam mnem_t M_AND    = 7'd3;
	localparam mnem_t M_ANDB   = 7'd4;
	localparam mnem_t M_BF     = 7'd5;
	localparam mnem_t M_BFS    = 7'd6;
	localparam mnem_t M_BRA    = 7'd7;
	localparam mnem_t M_BRAF   = 7'd8;
	localparam mnem_t M_BSR    = 7'd9;
	localparam mnem_t M_BSRF   = 7'd10;
	localparam mnem_t M_BT     = 7'd11;
	localparam mnem_t M_BTS    = 7'd12;
	localparam mnem_t M_CLRMAC = 7'd13;
	localparam mnem_t M_CLRT   = 7'd14;
	localparam mnem_t M_CMPEQ  = 7'd15;
	localparam mnem_t M_CMPGE  = 7'd16;
	localparam mnem_t M_CMPGT  = 7'd17;
	localparam mnem_t M_CMPHI  = 7'd18;
	localparam mnem_t M_CMPHS  = 7'd19;
	localparam mnem_t M_CMPPL  = 7'd20;
	localparam mnem_t M_CMPPZ  = 7'd21;
	localparam mnem_t M_CMPSTR = 7'd22;
	localparam mnem_t M_DIV0S  = 7'd23;
	localparam mnem_t M_DIV0U  = 7'd24;
	localparam mnem_t M_DIV1   = 7'd25;
	localparam mnem_t M_DT     = 7'd26;
	localparam mnem_t M_DMULU  = 7'd27;
	localparam mnem_t M_DMULS  = 7'd28;
	localparam mnem_t M_EXTSB  = 7'd29;
	localparam mnem_t M_EXTSW  = 7'd30;
	localparam mnem_t M_EXTUB  = 7'd31;
	localparam mnem_t M_EXTUW  = 7'd32;
	localparam mnem_t M_JMP    = 7'd33;
	localparam mnem_t M_JSR    = 7'd34;
	localparam mnem_t M_LDC    = 7'd35;
	localparam mnem_t M_LDCL   = 7'd36;
	localparam mnem_t M_LDS    = 7'd37;
	localparam mnem_t M_LDSL   = 7'd38;
	localparam mnem_t M_MACW   = 7'd39;
	localparam mnem_t M_MACL   = 7'd40;
	localparam mnem_t M_MOV    = 7'd41;
	localparam mnem_t M_MOVB   = 7'd42;
	localparam mnem_t M_MOVL   = 7'd43;
	localparam mnem_t M_MOVW   = 7'd44;
	localparam mnem_t M_MOVA   = 7'd45;
	localparam mnem_t M_MOVT   = 7'd46;
	localparam mnem_t M_MULS   = 7'd47;
	localparam mnem_t M_MULU   = 7'd48;
	localparam mnem_t M_MULL   = 7'd49;
	localparam mnem_t M_NEG    = 7'd50;
	localparam mnem_t M_NEGC   = 7'd51;
	localparam mnem_t M_NOP    = 7'd52;
	localparam mnem_t M_NOT    = 7'd53;
	localparam mnem_t M_OR     = 7'd54;
	localparam mnem_t M_ORB    = 7'd55;
	localparam mnem_t M_ROTCL  = 7'd56;
	localparam mnem_t M_ROTCR  = 7'd57;
	localparam mnem_t M_ROTL   = 7'd58;
	localparam mnem_t M_ROTR   = 7'd59;
	localparam mnem_t M_RTE    = 7'd60;
	localparam mnem_t M_RTS    = 7'd61;
	localparam mnem_t M_SETT   = 7'd62;
	localparam mnem_t M_SHAL   = 7'd63;
	localparam mnem_t M_SHAR   = 7'd64;
	localparam mnem_t M_SHLL   = 7'd65;
	localparam mnem_t M_SHLL2  = 7'd66;
	localparam mnem_t M_SHLL8  = 7'd67;
	localparam mnem_t M_SHLL16 = 7'd68;
	localparam mnem_t M_SHLR   = 7'd69;
	localparam mnem_t M_SHLR2  = 7'd70;
	localparam mnem_t M_SHLR8  = 7'd71;
	localparam mnem_t M_SHLR16 = 7'd72;
	localparam mnem_t M_SLEEP  = 7'd73;
	localparam mnem_t M_STC    = 7'd74;
	localparam mnem_t M_STCL   = 7'd75;
	localparam mnem_t M_STS    = 7'd76;
	localparam mnem_t M_STSL   = 7'd77;
	localparam mnem_t M_SUB    = 7'd78;
	localparam mnem_t M_SUBC   = 7'd79;
	localparam mnem_t M_SUBV   = 7'd80;
	localparam mnem_t M_SWAPB  = 7'd81;
	localparam mnem_t M_SWAPW  = 7'd82;
	localparam mnem_t M_TASB   = 7'd83;
	localparam mnem_t M_TRAPA  = 7'd84;
	localparam mnem_t M_TST    = 7'd85;
	localparam mnem_t M_TSTB   = 7'd86;
	localparam mnem_t M_XOR    = 7'd87;
	localparam mnem_t M_XORB   = 7'd88;
	localparam mnem_t M_XTRCT  = 7'd89;
	localparam mnem_t M_WORD   = 7'd90;

	// operand formats
	localparam fmt_t F_NONE      = 6'd0;
	localparam fmt_t F_IMM       = 6'd1;
	localparam fmt_t F_IMM_R0GBR = 6'd2;
	localparam fmt_t F_IMM_R0    = 6'd3;
	localparam fmt_t F_IMM_RN    = 6'd4;
	localparam fmt_t F_R0RM_RN   = 6'd5;
	localparam fmt_t F_DGBR_R0   = 6'd6;
	localparam fmt_t F_PC4_R0    = 6'd7;
	localparam fmt_t F_PC4_RN    = 6'd10;
	localparam fmt_t F_PC2_RN    = 6'd11;
	localparam fmt_t F_DRM_R0    = 6'd13;
	localparam fmt_t F_DRM_RN    = 6'd14;
	localparam fmt_t F_RMP_RNP   = 6'd15;
	localparam fmt_t F_RNP_GBR   = 6'd16;
	localparam fmt_t F_RNP_MACH  = 6'd17;
	localparam fmt_t F_RNP_MACL  = 6'd18;
	localparam fmt_t F_RNP_PR    = 6'd19;
	localparam fmt_t F_RMP_RN    = 6'd20;
	localparam fmt_t F_RNP_SR    = 6'd21;
	localparam fmt_t F_RNP_VBR   = 6'd22;
	localparam fmt_t F_ATRM_RN   = 6'd23;
	localparam fmt_t F_ATRN      = 6'd24;
	localparam fmt_t F_GBR_DEC   = 6'd25;
	localparam fmt_t F_GBR_RN    = 6'd26;
	localparam fmt_t F_MACH_DEC  = 6'd27;
	localparam fmt_t F_MACH_RN   = 6'd28;
	localparam fmt_t F_MACL_DEC  = 6'd29;
	localparam fmt_t F_MACL_RN   = 6'd30;
	localparam fmt_t F_PR_DEC    = 6'd31;
	localparam fmt_t F_PR_RN     = 6'd32;
	localparam fmt_t F_R0_DGBR   = 6'd33;
	localparam fmt_t F_R0_DRM    = 6'd34;
	localparam fmt_t F_RM_R0RN   = 6'd35;
	localparam fmt_t F_RM_DRN    = 6'd36;
	localparam fmt_t F_RM_DEC    = 6'd37;
	localparam fmt_t F_RM_ATRN   = 6'd38;
	localparam fmt_t F_RN_GBR    = 6'd39;
	localparam fmt_t F_RN_MACH   = 6'd40;
	localparam fmt_t F_RN_MACL   = 6'd41;
	localparam fmt_t F_RN_PR     = 6'd42;
	localparam fmt_t F_RM_RN     = 6'd43;
	localparam fmt_t F_RN_SR     = 6'd44;
	localparam fmt_t F_RN_VBR    = 6'd45;
	localparam fmt_t F_RN        = 6'd46;
	localparam fmt_t F_SR_DEC    = 6'd47;
	localparam fmt_t F_SR_RN     = 6'd48;
	localparam fmt_t F_VBR_DEC   = 6'd49;
	localparam fmt_t F_VBR_RN    = 6'd50;
	localparam fmt_t F_DISP      = 6'd51;
	localparam fmt_t F_BR12      = 6'd52;
	localparam fmt_t F_ALL       = 6'd53;

	localparam dec_t DEC_BAD = '{mnem: M_WORD, fmt: F_ALL};

	function automatic dec_t dec_grp0(input logic [3:0] rn, input logic [7:0] lo8);
		dec_t r;
		r = DEC_BAD;
		case (lo8[3:0])
			4'h4: r = '{M_MOVB, F_RM_R0RN};
			4'h5: r = '{M_MOVW, F_RM_R0RN};
			4'h6: r = '{M_MOVL, F_RM_R0RN};
			4'h7: r = '{M_MULL, F_RM_RN};
			4'hc: r = '{M_MOVB, F_R0RM_RN};
			4'hd: r = '{M_MOVW, F_R0RM_RN};
			4'he: r = '{M_MOVL, F_R0RM_RN};
			4'hf: r = '{M_MACL, F_RMP_RNP};
			default: r = DEC_BAD;
		endcase
		case (lo8)
			8'h02: r = '{M_STC, F_SR_RN};
			8'h03: r = '{M_BSRF, F_RN};
			8'h0a: r = '{M_STS, F_MACH_RN};
			8'h12: r = '{M_STC, F_GBR_RN};
			8'h1a: r = '{M_STS, F_MACL_RN};
			8'h22: r = '{M_STC, F_VBR_RN};
			8'h23: r = '{M_BRAF, F_RN};
			8'h29: r = '{M_MOVT, F_RN};
			8'h2a: r = '{M_STS, F_PR_RN};
			default: ;
		endcase
		if (rn == 4'h0) begin
			case (lo8)
				8'h08: r = '{M_CLRT, F_NONE};
				8'h09: r = '{M_NOP, F_NONE};
				8'h0b: r = '{M_RTS, F_NONE};
				8'h18: r = '{M_SETT, F_NONE};
				8'h19: r = '{M_DIV0U, F_NONE};
				8'h1b: r = '{M_SLEEP, F_NONE};
				8'h28: r = '{M_CLRMAC, F_NONE};
				8'h2b: r = '{M_RTE, F_NONE};
				default: ;
			endcase
		end
		return r;
	endfunction

	function automatic dec_t dec_grp4(input logic [7:0] lo8);
		dec_t r;
		case (lo8)
			8'h00: r = '{M_SHLL, F_RN};
			8'h01: r = '{M_SHLR, F_RN};
			8'h02: r = '{M_STSL, F_MACH_DEC};
			8'h03: r = '{M_STCL, F_SR_DEC};
			8'h04: r = '{M_ROTL, F_RN};
			8'h05: r = '{M_ROTR, F_RN};
			8'h06: r = '{M_LDSL, F_RNP_MACH};
			8'h07: r = '{M_LDCL, F_RNP_SR};
			8'h08: r = '{M_SHLL2, F_RN};
			8'h09: r = '{M_SHLR2, F_RN};
			8'h0a: r = '{M_LDS, F_RN_MACH};
			8'h0b: r = '{M_JSR, F_ATRN};
			8'h0e: r = '{M_LDC, F_RN_SR};
			8'h10: r = '{M_DT, F_RN};
			8'h11: r = '{M_CMPPZ, F_RN};
			8'h12: r = '{M_STSL, F_MACL_DEC};
			8'h13: r = '{M_STCL, F_GBR_DEC};
			8'h15: r = '{M_CMPPL, F_RN};
			8'h16: r = '{M_LDSL, F_RNP_MACL};
			8'h17: r = '{M_LDCL, F_RNP_GBR};
			8'h18: r = '{M_SHLL8, F_RN};
			8'h19: r = '{M_SHLR8, F_RN};
			8'h1a: r = '{M_LDS, F_RN_MACL};
			8'h1b: r = '{M_TASB, F_ATRN};
			8'h1e: r = '{M_LDC, F_RN_GBR};
			8'h20: r = '{M_SHAL, F_RN};
			8'h21: r = '{M_SHAR, F_RN};
			8'h22: r = '{M_STSL, F_PR_DEC};
			8'h23: r = '{M_STCL, F_VBR_DEC};
			8'h24: r = '{M_ROTCL, F_RN};
			8'h25: r = '{M_ROTCR, F_RN};
			8'h26: r = '{M_LDSL, F_RNP_PR};
			8'h27: r = '{M_LDCL, F_RNP_VBR};
			8'h28: r = '{M_SHLL16, F_RN};
			8'h29: r = '{M_SHLR16, F_RN};
			8'h2a: r = '{M_LDS, F_RN_PR};
			8'h2b: r = '{M_JMP, F_ATRN};
			8'h2e: r = '{M_LDC, F_RN_VBR};
			default: r = (lo8[3:0] == 4'hf) ? dec_t'{M_MACW, F_RMP_RNP} : DEC_BAD;
		endcase
		return r;
	endfunction

	function automatic dec_t dec_grp2(input logic [3:0] lo4);
		dec_t r;
		case (lo4)
			4'h0: r = '{M_MOVB, F_RM_ATRN};
			4'h1: r = '{M_MOVW, F_RM_ATRN};
			4'h2: r = '{M_MOVL, F_RM_ATRN};
			4'h4: r = '{M_MOVB, F_RM_DEC};
			4'h5: r = '{M_MOVW, F_RM_DEC};
			4'h6: r = '{M_MOVL, F_RM_DEC};
			4'h7: r = '{M_DIV0S, F_RM_RN};
			4'h8: r = '{M_TST, F_RM_RN};
			4'h9: r = '{M_AND, F_RM_RN};
			4'ha: r = '{M_XOR, F_RM_RN};
			4'hb: r = '{M_OR, F_RM_RN};
			4'hc: r = '{M_CMPSTR, F_RM_RN};
			4'hd: r = '{M_XTRCT, F_RM_RN};
			4'he: r = '{M_MULU, F_RM_RN};
			4'hf: r = '{M_MULS, F_RM_RN};
			default: r = DEC_BAD;
		endcase
		return r;
	endfunction

	function automatic dec_t dec_grp3(input logic [3:0] lo4);
		dec_t r;
		case (lo4)
			4'h0: r = '{M_CMPEQ, F_RM_RN};
			4'h2: r = '{M_CMPHS, F_RM_RN};
			4'h3: r = '{M_CMPGE, F_RM_RN};
			4'h4: r = '{M_DIV1, F_RM_RN};
			4'h5: r = '{M_DMULU, F_RM_RN};
			4'h6: r = '{M_CMPHI, F_RM_RN};
			4'h7: r = '{M_CMPGT, F_RM_RN};
			4'h8: r = '{M_SUB, F_RM_RN};
			4'ha: r = '{M_SUBC, F_RM_RN};
			4'hb: r = '{M_SUBV, F_RM_RN};
			4'hc: r = '{M_ADD, F_RM_RN};
			4'hd: r = '{M_DMULS, F_RM_RN};
			4'he: r = '{M_ADDC, F_RM_RN};
			4'hf: r = '{M_ADDV, F_RM_RN};
			default: r = DEC_BAD;
		endcase
		return r;
	endfunction

	function automatic dec_t dec_grp6(input logic [3:0] lo4);
		dec_t r;
		case (lo4)
			4'h0: r = '{M_MOVB, F_ATRM_RN};
			4'h1: r = '{M_MOVW, F_ATRM_RN};
			4'h2: r = '{M_MOVL, F_ATRM_RN};
			4'h3: r = '{M_MOV, F_RM_RN};
			4'h4: r = '{M_MOVB, F_RMP_RN};
			4'h5: r = '{M_MOVW, F_RMP_RN};
			4'h6: r = '{M_MOVL, F_RMP_RN};
			4'h7: r = '{M_NOT, F_RM_RN};
			4'h8: r = '{M_SWAPB, F_RM_RN};
			4'h9: r = '{M_SWAPW, F_RM_RN};
			4'ha: r = '{M_NEGC, F_RM_RN};
			4'hb: r = '{M_NEG, F_RM_RN};
			4'hc: r = '{M_EXTUB, F_RM_RN};
			4'hd: r = '{M_EXTUW, F_RM_RN};
			4'he: r = '{M_EXTSB, F_RM_RN};
			default: r = '{M_EXTSW, F_RM_RN};
		endcase
		return r;
	endfunction

	function automatic dec_t dec_grp8(input logic [3:0] rn);
		dec_t r;
		case (rn)
			4'h0: r = '{M_MOVB, F_R0_DRM};
			4'h1: r = '{M_MOVW, F_R0_DRM};
			4'h4: r = '{M_MOVB, F_DRM_R0};
			4'h5: r = '{M_MOVW, F_DRM_R0};
			4'h8: r = '{M_CMPEQ, F_IMM_R0};
			4'h9: r = '{M_BT, F_DISP};
			4'hb: r = '{M_BF, F_DISP};
			4'hd: r = '{M_BTS, F_DISP};
			4'hf: r = '{M_BFS, F_DISP};
			default: r = DEC_BAD;
		endcase
		return r;
	endfunction

	function automatic dec_t dec_grpc(input logic [3:0] rn);
		dec_t r;
		case (rn)
			4'h0: r = '{M_MOVB, F_R0_DGBR};
			4'h1: r = '{M_MOVW, F_R0_DGBR};
			4'h2: r = '{M_MOVL, F_R0_DGBR};
			4'h3: r = '{M_TRAPA, F_IMM};
			4'h4: r = '{M_MOVB, F_DGBR_R0};
			4'h5: r = '{M_MOVW, F_DGBR_R0};
			4'h6: r = '{M_MOVL, F_DGBR_R0};
			4'h7: r = '{M_MOVA, F_PC4_R0};
			4'h8: r = '{M_TST, F_IMM_R0};
			4'h9: r = '{M_AND, F_IMM_R0};
			4'ha: r = '{M_XOR, F_IMM_R0};
			4'hb: r = '{M_OR, F_IMM_R0};
			4'hc: r = '{M_TSTB, F_IMM_R0GBR};
			4'hd: r = '{M_ANDB, F_IMM_R0GBR};
			4'he: r = '{M_XORB, F_IMM_R0GBR};
			default: r = '{M_ORB, F_IMM_R0GBR};
		endcase
		return r;
	endfunction

	function automatic dec_t decode_word(input logic [15:0] w);
		dec_t r;
		case (w[15:12])
			4'h0: r = dec_grp0(w[11:8], w[7:0]);
			4'h1: r = '{M_MOVL, F_RM_DRN};
			4'h2: r = dec_grp2(w[3:0]);
			4'h3: r = dec_grp3(w[3:0]);
			4'h4: r = dec_grp4(w[7:0]);
			4'h5: r = '{M_MOVL, F_DRM_RN};
			4'h6: r = dec_grp6(w[3:0]);
			4'h7: r = '{M_ADD, F_IMM_RN};
			4'h8: r = dec_grp8(w[11:8]);
			4'h9: r = '{M_MOVW, F_PC2_RN};
			4'ha: r = '{M_BRA, F_BR12};
			4'hb: r = '{M_BSR, F_BR12};
			4'hc: r = dec_grpc(w[11:8]);
			4'hd: r = '{M_MOVL, F_PC4_RN};
			4'he: r = '{M_MOV, F_IMM_RN};
			default: r = DEC_BAD;
		endcase
		return r;
	endfunction

	function automatic logic has_delay(input mnem_t m);
		return (m == M_BFS) || (m == M_BTS) || (m == M_BRA) || (m == M_BRAF) ||
			(m == M_BSR) || (m == M_BSRF) || (m == M_JMP) || (m == M_JSR) ||
			(m == M_RTE) || (m == M_RTS);
	endfunction

endpackage

>>> hdl/risc16_instruction_decode.sv
`timescale 1ns / 1ps
// Pipeline: two registers (input register, then decode into the result register).
// Throughput: one item per cycle while m_tready is high; the result register frees
// whenever m_tready is high, so input and output advance together.
// Reset: arst_n clears both valid flags at once; payload registers are not reset.
// ----------------------------------------------------------------------------
// risc16_instruction_decode
// Decodes one 16-bit instruction word into mnemonic, operand format, raw
// register and immediate fields, delay-slot and illegal flags.
// ----------------------------------------------------------------------------
module risc16_instruction_decode (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [15:0] instr_word
	output logic        m_tvalid,
	input  logic        m_tready,
	// [6:0] mnemonic, [12:7] operand_format, [16:13] reg_n, [20:17] reg_m,
	// [24:21] low_nibble, [32:25] imm_byte, [44:33] branch_disp, [45] delayed,
	// [47:46] zero
	output logic [47:0] m_tdata,
	output logic        m_tuser   // [0] illegal
);
	import r16id_pkg::*;

	logic        valid_s1;
	logic [15:0] word_s1;
	logic        valid_s2;
	logic [11:0] word_s2;
	dec_t        dec_s2;
	logic        delayed_s2;
	logic        illegal_s2;

	dec_t        dec_c;
	logic        adv_s2;
	logic        adv_s1;

	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign s_tready = adv_s1;
	assign dec_c    = decode_word(word_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// hold payload while stalled
	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			word_s1 <= s_tdata;
		end
		if (adv_s2 && valid_s1) begin
			word_s2    <= word_s1[11:0];
			dec_s2     <= dec_c;
			delayed_s2 <= has_delay(dec_c.mnem);
			illegal_s2 <= (dec_c.mnem == M_WORD);
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = illegal_s2;
	assign m_tdata  = {2'b00, delayed_s2, word_s2[11:0], word_s2[7:0], word_s2[3:0],
		word_s2[7:4], word_s2[11:8], dec_s2.fmt, dec_s2.mnem};

`ifndef SYNTHESIS
	a_illegal_whole_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata[6:0] == M_WORD) && (m_tdata[12:7] == F_ALL))
		else $error("illegal item without whole-word format");

	a_illegal_no_delay: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> !m_tdata[45])
		else $error("illegal item flagged as delayed");

	a_fields_agree: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[44:41] == m_tdata[16:13]) &&
			(m_tdata[32:29] == m_tdata[20:17]) && (m_tdata[28:25] == m_tdata[24:21]))
		else $error("raw fields disagree");

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

	a_item_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !valid_s2 |=> valid_s2)
		else $error("item lost between stages");
`endif

endmodule

>>> dv/risc16_decode_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// risc16_decode_checker
// Watches both stream channels of the instruction decoder. Every accepted
// instruction word is decoded here independently, and each accepted result
// is checked field by field against the oldest outstanding decode.
// ----------------------------------------------------------------------------
module risc16_decode_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,  // [15:0] instr_word
	input  logic        m_tvalid,
	input  logic        m_tready,
	// [6:0] mnemonic, [12:7] operand_format, [16:13] reg_n, [20:17] reg_m,
	// [24:21] low_nibble, [32:25] imm_byte, [44:33] branch_disp, [45] delayed,
	// [47:46] zero
	input  logic [47:0] m_tdata,
	input  logic        m_tuser,  // [0] illegal
	output int          fail_count,
	output int          left_count,
	output int          checked_count,
	output int          illegal_count,
	output int          delayed_count,
	output int          mnem_count
);
	import r16id_pkg::*;

	typedef struct packed {
		logic [15:0] word;
		mnem_t       mnem;
		fmt_t        fmt;
		logic [3:0]  rn;
		logic [3:0]  rm;
		logic [3:0]  lo4;
		logic [7:0]  imm;
		logic [11:0] disp;
		logic        dly;
		logic        bad;
	} decode_t;

	decode_t      pending_decodes[$];
	int           errors   = 0;
	int           checked  = 0;
	int           illegals = 0;
	int           slots    = 0;
	logic [127:0] seen     = '0;

	initial begin
		fail_count    = 0;
		left_count    = 0;
		checked_count = 0;
		illegal_count = 0;
		delayed_count = 0;
		mnem_count    = 0;
	end

	function automatic decode_t expected_decode(input logic [15:0] w);
		decode_t    d;
		mnem_t      m;
		fmt_t       f;
		logic       hit;
		logic [3:0] rn;
		logic [3:0] lo4;
		logic [7:0] lo8;
		rn  = w[11:8];
		lo8 = w[7:0];
		lo4 = w[3:0];
		m   = M_WORD;
		f   = F_ALL;
		case (w[15:12])
			4'h0: begin
				// whole-word matches first, then the low byte, then the low nibble
				hit = 1'b0;
				if (rn == 4'h0) begin
					hit = 1'b1;
					case (lo8)
						8'h08: m = M_CLRT;
						8'h09: m = M_NOP;
						8'h0b: m = M_RTS;
						8'h18: m = M_SETT;
						8'h19: m = M_DIV0U;
						8'h1b: m = M_SLEEP;
						8'h28: m = M_CLRMAC;
						8'h2b: m = M_RTE;
						default: hit = 1'b0;
					endcase
					if (hit)
						f = F_NONE;
				end
				if (!hit) begin
					hit = 1'b1;
					case (lo8)
						8'h02: begin m = M_STC;  f = F_SR_RN;   end
						8'h03: begin m = M_BSRF; f = F_RN;      end
						8'h0a: begin m = M_STS;  f = F_MACH_RN; end
						8'h12: begin m = M_STC;  f = F_GBR_RN;  end
						8'h1a: begin m = M_STS;  f = F_MACL_RN; end
						8'h22: begin m = M_STC;  f = F_VBR_RN;  end
						8'h23: begin m = M_BRAF; f = F_RN;      end
						8'h29: begin m = M_MOVT; f = F_RN;      end
						8'h2a: begin m = M_STS;  f = F_PR_RN;   end
						default: hit = 1'b0;
					endcase
				end
				if (!hit) begin
					case (lo4)
						4'h4: begin m = M_MOVB; f = F_RM_R0RN; end
						4'h5: begin m = M_MOVW; f = F_RM_R0RN; end
						4'h6: begin m = M_MOVL; f = F_RM_R0RN; end
						4'h7: begin m = M_MULL; f = F_RM_RN;   end
						4'hc: begin m = M_MOVB; f = F_R0RM_RN; end
						4'hd: begin m = M_MOVW; f = F_R0RM_RN; end
						4'he: begin m = M_MOVL; f = F_R0RM_RN; end
						4'hf: begin m = M_MACL; f = F_RMP_RNP; end
						default: ;
					endcase
				end
			end
			4'h1: begin m = M_MOVL; f = F_RM_DRN; end
			4'h2: begin
				case (lo4)
					4'h0, 4'h4: m = M_MOVB;
					4'h1, 4'h5: m = M_MOVW;
					4'h2, 4'h6: m = M_MOVL;
					4'h7: m = M_DIV0S;
					4'h8: m = M_TST;
					4'h9: m = M_AND;
					4'ha: m = M_XOR;
					4'hb: m = M_OR;
					4'hc: m = M_CMPSTR;
					4'hd: m = M_XTRCT;
					4'he: m = M_MULU;
					4'hf: m = M_MULS;
					default: ;
				endcase
				if (m != M_WORD)
					f = (lo4 < 4'h3) ? F_RM_ATRN : (lo4 < 4'h7) ? F_RM_DEC : F_RM_RN;
			end
			4'h3: begin
				case (lo4)
					4'h0: m = M_CMPEQ;
					4'h2: m = M_CMPHS;
					4'h3: m = M_CMPGE;
					4'h4: m = M_DIV1;
					4'h5: m = M_DMULU;
					4'h6: m = M_CMPHI;
					4'h7: m = M_CMPGT;
					4'h8: m = M_SUB;
					4'ha: m = M_SUBC;
					4'hb: m = M_SUBV;
					4'hc: m = M_ADD;
					4'hd: m = M_DMULS;
					4'he: m = M_ADDC;
					4'hf: m = M_ADDV;
					default: ;
				endcase
				if (m != M_WORD)
					f = F_RM_RN;
			end
			4'h4: begin
				case (lo8)
					8'h00: begin m = M_SHLL;   f = F_RN;       end
					8'h01: begin m = M_SHLR;   f = F_RN;       end
					8'h02: begin m = M_STSL;   f = F_MACH_DEC; end
					8'h03: begin m = M_STCL;   f = F_SR_DEC;   end
					8'h04: begin m = M_ROTL;   f = F_RN;       end
					8'h05: begin m = M_ROTR;   f = F_RN;       end
					8'h06: begin m = M_LDSL;   f = F_RNP_MACH; end
					8'h07: begin m = M_LDCL;   f = F_RNP_SR;   end
					8'h08: begin m = M_SHLL2;  f = F_RN;       end
					8'h09: begin m = M_SHLR2;  f = F_RN;       end
					8'h0a: begin m = M_LDS;    f = F_RN_MACH;  end
					8'h0b: begin m = M_JSR;    f = F_ATRN;     end
					8'h0e: begin m = M_LDC;    f = F_RN_SR;    end
					8'h10: begin m = M_DT;     f = F_RN;       end
					8'h11: begin m = M_CMPPZ;  f = F_RN;       end
					8'h12: begin m = M_STSL;   f = F_MACL_DEC; end
					8'h13: begin m = M_STCL;   f = F_GBR_DEC;  end
					8'h15: begin m = M_CMPPL;  f = F_RN;       end
					8'h16: begin m = M_LDSL;   f = F_RNP_MACL; end
					8'h17: begin m = M_LDCL;   f = F_RNP_GBR;  end
					8'h18: begin m = M_SHLL8;  f = F_RN;       end
					8'h19: begin m = M_SHLR8;  f = F_RN;       end
					8'h1a: begin m = M_LDS;    f = F_RN_MACL;  end
					8'h1b: begin m = M_TASB;   f = F_ATRN;     end
					8'h1e: begin m = M_LDC;    f = F_RN_GBR;   end
					8'h20: begin m = M_SHAL;   f = F_RN;       end
					8'h21: begin m = M_SHAR;   f = F_RN;       end
					8'h22: begin m = M_STSL;   f = F_PR_DEC;   end
					8'h23: begin m = M_STCL;   f = F_VBR_DEC;  end
					8'h24: begin m = M_ROTCL;  f = F_RN;       end
					8'h25: begin m = M_ROTCR;  f = F_RN;       end
					8'h26: begin m = M_LDSL;   f = F_RNP_PR;   end
					8'h27: begin m = M_LDCL;   f = F_RNP_VBR;  end
					8'h28: begin m = M_SHLL16; f = F_RN;       end
					8'h29: begin m = M_SHLR16; f = F_RN;       end
					8'h2a: begin m = M_LDS;    f = F_RN_PR;    end
					8'h2b: begin m = M_JMP;    f = F_ATRN;     end
					8'h2e: begin m = M_LDC;    f = F_RN_VBR;   end
					default: begin
						if (lo4 == 4'hf) begin
							m = M_MACW;
							f = F_RMP_RNP;
						end
					end
				endcase
			end
			4'h5: begin m = M_MOVL; f = F_DRM_RN; end
			4'h6: begin
				case (lo4)
					4'h0, 4'h4: m = M_MOVB;
					4'h1, 4'h5: m = M_MOVW;
					4'h2, 4'h6: m = M_MOVL;
					4'h3: m = M_MOV;
					4'h7: m = M_NOT;
					4'h8: m = M_SWAPB;
					4'h9: m = M_SWAPW;
					4'ha: m = M_NEGC;
					4'hb: m = M_NEG;
					4'hc: m = M_EXTUB;
					4'hd: m = M_EXTUW;
					4'he: m = M_EXTSB;
					default: m = M_EXTSW;
				endcase
				if (lo4 < 4'h3)
					f = F_ATRM_RN;
				else if (lo4 >= 4'h4 && lo4 <= 4'h6)
					f = F_RMP_RN;
				else
					f = F_RM_RN;
			end
			4'h7: begin m = M_ADD; f = F_IMM_RN; end
			4'h8: begin
				case (rn)
					4'h0: begin m = M_MOVB;  f = F_R0_DRM; end
					4'h1: begin m = M_MOVW;  f = F_R0_DRM; end
					4'h4: begin m = M_MOVB;  f = F_DRM_R0; end
					4'h5: begin m = M_MOVW;  f = F_DRM_R0; end
					4'h8: begin m = M_CMPEQ; f = F_IMM_R0; end
					4'h9: begin m = M_BT;    f = F_DISP;   end
					4'hb: begin m = M_BF;    f = F_DISP;   end
					4'hd: begin m = M_BTS;   f = F_DISP;   end
					4'hf: begin m = M_BFS;   f = F_DISP;   end
					default: ;
				endcase
			end
			4'h9: begin m = M_MOVW; f = F_PC2_RN; end
			4'ha: begin m = M_BRA;  f = F_BR12;   end
			4'hb: begin m = M_BSR;  f = F_BR12;   end
			4'hc: begin
				case (rn)
					4'h0, 4'h4: m = M_MOVB;
					4'h1, 4'h5: m = M_MOVW;
					4'h2, 4'h6: m = M_MOVL;
					4'h3: m = M_TRAPA;
					4'h7: m = M_MOVA;
					4'h8: m = M_TST;
					4'h9: m = M_AND;
					4'ha: m = M_XOR;
					4'hb: m = M_OR;
					4'hc: m = M_TSTB;
					4'hd: m = M_ANDB;
					4'he: m = M_XORB;
					default: m = M_ORB;
				endcase
				if (rn < 4'h3)
					f = F_R0_DGBR;
				else if (rn == 4'h3)
					f = F_IMM;
				else if (rn < 4'h7)
					f = F_DGBR_R0;
				else if (rn == 4'h7)
					f = F_PC4_R0;
				else if (rn < 4'hc)
					f = F_IMM_R0;
				else
					f = F_IMM_R0GBR;
			end
			4'hd: begin m = M_MOVL; f = F_PC4_RN; end
			4'he: begin m = M_MOV;  f = F_IMM_RN; end
			default: ;
		endcase
		d.word = w;
		d.mnem = m;
		d.fmt  = f;
		d.rn   = rn;
		d.rm   = w[7:4];
		d.lo4  = lo4;
		d.imm  = lo8;
		d.disp = w[11:0];
		case (m)
			M_BFS, M_BTS, M_BRA, M_BRAF, M_BSR, M_BSRF, M_JMP, M_JSR, M_RTE, M_RTS:
				d.dly = 1'b1;
			default:
				d.dly = 1'b0;
		endcase
		d.bad = (m == M_WORD);
		return d;
	endfunction

	task automatic compare_field(input string name, input logic [15:0] word,
		input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: word %h %s expected %0d actual %0d", $time, word, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : watch
		decode_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_decodes.size() == 0) begin
					$display("%0t: result %h/%b with no word outstanding", $time, m_tdata, m_tuser);
					errors++;
				end else begin
					want = pending_decodes.pop_front();
					compare_field("mnemonic", want.word, 16'(want.mnem), 16'(m_tdata[6:0]));
					compare_field("operand_format", want.word, 16'(want.fmt),
						16'(m_tdata[12:7]));
					compare_field("reg_n", want.word, 16'(want.rn), 16'(m_tdata[16:13]));
					compare_field("reg_m", want.word, 16'(want.rm), 16'(m_tdata[20:17]));
					compare_field("low_nibble", want.word, 16'(want.lo4), 16'(m_tdata[24:21]));
					compare_field("imm_byte", want.word, 16'(want.imm), 16'(m_tdata[32:25]));
					compare_field("branch_disp", want.word, 16'(want.disp),
						16'(m_tdata[44:33]));
					compare_field("delayed", want.word, 16'(want.dly), 16'(m_tdata[45]));
					compare_field("pad", want.word, 16'd0, 16'(m_tdata[47:46]));
					compare_field("illegal", want.word, 16'(want.bad), 16'(m_tuser));
					checked++;
					illegals += int'(want.bad);
					slots    += int'(want.dly);
					seen[want.mnem] = 1'b1;
				end
			end
			if (s_tvalid && s_tready)
				pending_decodes.push_back(expected_decode(s_tdata));
		end
		fail_count    <= errors;
		left_count    <= pending_decodes.size();
		checked_count <= checked;
		illegal_count <= illegals;
		delayed_count <= slots;
		mnem_count    <= $countones(seen);
	end

endmodule

>>> dv/tb_risc16_instruction_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_risc16_instruction_decode
// Feeds the instruction decoder a directed set of corner words followed by
// mostly well-formed random instructions, with random gaps on the input and
// random back-pressure on the output. Checking is done by the decode checker.
// ----------------------------------------------------------------------------
module tb_risc16_instruction_decode;

	localparam int NumRandom  = 1425;
	localparam int CycleLimit = 400000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic        m_tuser;

	int src_mode = 0;
	int snk_mode = 0;
	int cycles   = 0;
	int fail_count;
	int left_count;
	int checked_count;
	int illegal_count;
	int delayed_count;
	int mnem_count;

	risc16_instruction_decode dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	risc16_decode_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.fail_count    (fail_count),
		.left_count    (left_count),
		.checked_count (checked_count),
		.illegal_count (illegal_count),
		.delayed_count (delayed_count),
		.mnem_count    (mnem_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("run stopped after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end
	end

	// mode 0 never idles, mode 1 idles now and then, mode 2 idles often
	function automatic int idle_len(input int mode);
		int r;
		if (mode == 0)
			return 0;
		r = $urandom_range(0, 99);
		if (r < ((mode == 1) ? 60 : 25))
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic logic [15:0] random_word();
		logic [15:0] w;
		w = 16'($urandom);
		if ($urandom_range(0, 99) < 25)
			return w;
		case (w[15:12])
			4'h0: begin
				case ($urandom_range(0, 2))
					0: begin
						w[11:8] = 4'h0;
						w[7:4]  = 4'($urandom_range(0, 2));
						case ($urandom_range(0, 2))
							0: w[3:0] = 4'h8;
							1: w[3:0] = 4'h9;
							default: w[3:0] = 4'hb;
						endcase
					end
					1: begin
						w[7:4] = 4'($urandom_range(0, 2));
						case ($urandom_range(0, 3))
							0: w[3:0] = 4'h2;
							1: w[3:0] = 4'h3;
							2: w[3:0] = 4'h9;
							default: w[3:0] = 4'ha;
						endcase
					end
					default: w[2] = 1'b1;
				endcase
			end
			4'h4: begin
				w[7:4] = 4'($urandom_range(0, 2));
				if ($urandom_range(0, 7) == 0)
					w[3:0] = 4'hf;
			end
			default: ;
		endcase
		return w;
	endfunction

	// hold the word until it is taken; keep tvalid high across back-to-back items
	task automatic send_word(input logic [15:0] w);
		int gap;
		gap = idle_len(src_mode);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			stall = idle_len(snk_mode);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(16'h0008);
		send_word(16'h0009);
		send_word(16'h000b);
		send_word(16'h0018);
		send_word(16'h0019);
		send_word(16'h001b);
		send_word(16'h0028);
		send_word(16'h002b);
		send_word(16'h0f08);
		send_word(16'h052b);
		send_word(16'h4306);
		send_word(16'h0b23);
		send_word(16'h0000);
		send_word(16'hffff);
		send_word(16'h2003);
		send_word(16'h3109);
		send_word(16'h8f80);
		send_word(16'h8d7f);
		send_word(16'ha000);
		send_word(16'hbfff);
		send_word(16'h4e2b);
		send_word(16'h410b);
		send_word(16'hc3a5);
		send_word(16'h4c0c);
		send_word(16'h4adf);

		for (int i = 0; i < NumRandom; i++) begin
			if (i % 150 == 0) begin
				src_mode = $urandom_range(0, 2);
				snk_mode = $urandom_range(0, 2);
			end
			send_word(random_word());
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (left_count != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("decoded %0d words: %0d illegal, %0d with a delay slot, %0d mnemonic codes hit",
			checked_count, illegal_count, delayed_count, mnem_count);
		$display("directed corner words then %0d random words under source gaps and sink stalls",
			NumRandom);
		if (fail_count == 0 && left_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
